>>> hdl/layer_z_order_stack_macros.svh
// Assertion macros for the layer z-order stack.
// Taken in by every RTL file that carries concurrent assertions.
`ifndef LAYER_Z_ORDER_STACK_MACROS_SVH
`define LAYER_Z_ORDER_STACK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lzs_pkg.sv
// Shared codes and control structures of the layer z-order stack.
// No dependencies; used by the level cells, the slot pool and the top level.
`timescale 1ns / 1ps

package lzs_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_ALLOC      = 2'd0;
    localparam logic [1:0] OP_SET_HEIGHT = 2'd1;
    localparam logic [1:0] OP_READ_LEVEL = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // Height reported for a hidden layer.
    localparam logic signed [4:0] HEIGHT_HIDDEN = -5'sd1;

    // The free-slot search examines this many slots per cycle.
    localparam int unsigned SCAN_CHUNK = 8;
    localparam int unsigned SCAN_OFS_W = 3;

    // Command to the row of level cells.
    typedef struct packed {
        logic remove;
        logic insert;
    } cell_ctrl_t;

    // Outcome of one step of the free-slot search.
    typedef struct packed {
        logic hit;
        logic miss;
    } pool_stat_t;

endpackage

>>> hdl/lzs_cell.sv
// One level of the stacking order: holds the layer shown at that level.
// Depends on lzs_pkg for the cell command structure.
`timescale 1ns / 1ps

module lzs_cell #(
    parameter  int unsigned SLOTS = 16,
    parameter  int unsigned IDX   = 0,
    localparam int unsigned LW    = $clog2(SLOTS),
    localparam int unsigned CW    = $clog2(SLOTS + 1)
) (
    input  logic                 aclk,
    input  lzs_pkg::cell_ctrl_t  ctrl,
    input  logic [LW-1:0]        thr,
    input  logic [LW-1:0]        layer_in,
    input  logic [LW-1:0]        rd_level,
    input  logic [CW-1:0]        count,
    input  logic [LW-1:0]        entry_up,
    input  logic [LW-1:0]        entry_dn,
    output logic [LW-1:0]        entry,
    output logic                 match,
    output logic [LW-1:0]        rd_data
);

    localparam logic [LW-1:0] MY_LEVEL   = LW'(IDX);
    localparam logic [CW-1:0] MY_LEVEL_C = CW'(IDX);

    logic [LW-1:0] entry_reg, entry_next;
    logic          live;

    always_comb begin
        live       = MY_LEVEL_C < count;
        entry_next = entry_reg;
        // Removal closes the gap by pulling from above; insertion opens one by
        // pushing up from below.
        priority if (ctrl.remove && (MY_LEVEL >= thr)) begin
            entry_next = entry_up;
        end else if (ctrl.insert && (MY_LEVEL > thr)) begin
            entry_next = entry_dn;
        end else if (ctrl.insert && (MY_LEVEL == thr)) begin
            entry_next = layer_in;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign match   = live && (entry_reg == layer_in);
    assign rd_data = (live && (MY_LEVEL == rd_level)) ? entry_reg : '0;

endmodule

>>> hdl/lzs_pool.sv
// Pool of layer slots: in-use marks and the lowest-free-slot search.
// Depends on lzs_pkg for the search chunk size and status structure.
`timescale 1ns / 1ps

module lzs_pool #(
    parameter  int unsigned SLOTS = 16,
    localparam int unsigned LW    = $clog2(SLOTS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                scan_en,
    input  logic [LW-1:0]       rd_idx,
    output logic                rd_in_use,
    output lzs_pkg::pool_stat_t stat,
    output logic [LW-1:0]       hit_idx
);

    localparam int unsigned NCH  = (SLOTS + lzs_pkg::SCAN_CHUNK - 1) / lzs_pkg::SCAN_CHUNK;
    localparam int unsigned CCW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int unsigned PADW = NCH * lzs_pkg::SCAN_CHUNK;

    logic [SLOTS-1:0]                  in_use_reg, in_use_next;
    logic [CCW-1:0]                    chunk_reg, chunk_next;
    logic [PADW-1:0]                   padded;
    logic [lzs_pkg::SCAN_CHUNK-1:0]    free_bits;
    logic [lzs_pkg::SCAN_OFS_W-1:0]    ofs;
    logic                              any_free;
    logic                              last_chunk;

    always_comb begin
        // Slots beyond the pool size look permanently taken.
        padded              = '1;
        padded[SLOTS-1:0]   = in_use_reg;
        free_bits           = ~padded[chunk_reg * lzs_pkg::SCAN_CHUNK +: lzs_pkg::SCAN_CHUNK];
        any_free            = |free_bits;
        ofs                 = '0;
        for (int i = lzs_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                ofs = lzs_pkg::SCAN_OFS_W'(i);
            end
        end
        hit_idx    = LW'({chunk_reg, ofs});
        last_chunk = chunk_reg == CCW'(NCH - 1);
        stat.hit   = scan_en && any_free;
        stat.miss  = scan_en && !any_free && last_chunk;

        if (!scan_en || any_free || last_chunk) begin
            chunk_next = '0;
        end else begin
            chunk_next = chunk_reg + CCW'(1);
        end

        in_use_next = in_use_reg;
        if (stat.hit) begin
            in_use_next[hit_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            chunk_reg  <= '0;
        end else begin
            in_use_reg <= in_use_next;
            chunk_reg  <= chunk_next;
        end
    end

    assign rd_in_use = in_use_reg[rd_idx];

endmodule

>>> hdl/layer_z_order_stack.sv
// Layer z-order stack: pool of layer slots with an ordered row of level cells.
// Top level; depends on lzs_pkg, lzs_pool, lzs_cell and the assertion macros.
`timescale 1ns / 1ps
`include "layer_z_order_stack_macros.svh"

// The block keeps the stacking order of up to SLOTS display layers and handles
// one item at a time. A read item passes the accepting state and a state that
// hands over the result, and a set-height item passes the accepting state, a
// state to find the layer in the row of level cells, one to close the gap it
// leaves, one to open a gap at the clamped height and drop it in, and one to
// hand over the result. An allocate item has a search state between the two,
// in which the free-slot search walks eight slots at a time until it finds a
// free one or has seen the last chunk. The hand-over state waits until the
// output register is free. The result sits in an output register, so the
// block goes back to accepting items while a result still waits on m_ready.
// Slots are never released; set-height on a slot that was never allocated,
// or on a slot number beyond the pool, answers status 2 and changes nothing.
// layer_out carries the low bits of a wider internal value when SLOTS exceeds
// sixteen, and shown_count does so when SLOTS exceeds thirty-one.

module layer_z_order_stack #(
    parameter int unsigned SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [3:0]        s_layer,
    input  logic signed [7:0] s_height,
    input  logic [3:0]        s_level,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [3:0]        m_layer_out,
    output logic signed [4:0] m_height_out,
    output logic [4:0]        m_shown_count
);

    localparam int unsigned LW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);
    // Signed width that holds both the requested height and the shown count.
    localparam int unsigned HW = (CW + 1 > 8) ? CW + 1 : 8;
    localparam logic signed [HW-1:0] H_HIDE = '1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ALLOC  = 6'b000010,
        S_FIND   = 6'b000100,
        S_REMOVE = 6'b001000,
        S_INSERT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Latched input item and intermediate results.
    logic [3:0]        layer_reg, layer_next;
    logic signed [7:0] height_reg, height_next;
    logic              found_reg, found_next;
    logic [LW-1:0]     p_reg, p_next;
    logic [CW-1:0]     count_reg, count_next;

    // Pending result, waiting for the output register.
    logic [1:0]        res_status_reg, res_status_next;
    logic [3:0]        res_layer_reg, res_layer_next;
    logic signed [4:0] res_height_reg, res_height_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [3:0]        m_layer_reg, m_layer_next;
    logic signed [4:0] m_height_reg, m_height_next;
    logic [4:0]        m_count_reg, m_count_next;

    // Cell row and pool wiring.
    lzs_pkg::cell_ctrl_t cell_ctrl;
    logic [LW-1:0]       cell_thr;
    logic [LW-1:0]       layer_idx;
    logic [LW-1:0]       level_idx;
    logic [LW-1:0]       entry_w [SLOTS];
    logic [LW-1:0]       rd_w [SLOTS];
    logic [SLOTS-1:0]    match_vec;
    logic [LW-1:0]       rd_hit;
    logic [LW-1:0]       p_enc;
    logic                match_any;

    logic                pool_scan;
    logic                pool_in_use;
    lzs_pkg::pool_stat_t pool_stat;
    logic [LW-1:0]       pool_idx;

    // Height clamping.
    logic signed [HW-1:0] h_req;
    logic signed [HW-1:0] cnt_s;
    logic signed [HW-1:0] h_cl;
    logic signed [HW-1:0] h_app;
    logic                 do_ins;

    logic accept;
    logic out_free;
    logic layer_ok;
    logic level_ok;

    lzs_pool #(
        .SLOTS (SLOTS)
    ) u_pool (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_en   (pool_scan),
        .rd_idx    (LW'(s_layer)),
        .rd_in_use (pool_in_use),
        .stat      (pool_stat),
        .hit_idx   (pool_idx)
    );

    // Level cells: cell g holds the layer shown at level g. Each one takes its
    // upper neighbour's entry on removal and its lower neighbour's on insertion.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lzs_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .thr      (cell_thr),
            .layer_in (layer_idx),
            .rd_level (level_idx),
            .count    (count_reg),
            .entry_up (entry_w[(g + 1 < SLOTS) ? g + 1 : g]),
            .entry_dn (entry_w[(g > 0) ? g - 1 : 0]),
            .entry    (entry_w[g]),
            .match    (match_vec[g]),
            .rd_data  (rd_w[g])
        );
    end

    assign layer_idx = LW'(layer_reg);
    assign level_idx = LW'(s_level);

    // Gather the read port and encode the match position. Since every shown
    // layer appears at most once, the match vector is one-hot or empty.
    always_comb begin
        rd_hit = '0;
        p_enc  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            rd_hit = rd_hit | rd_w[i];
            if (match_vec[i]) begin
                p_enc = p_enc | LW'(i);
            end
        end
        match_any = |match_vec;
    end

    // Clamp the request against the shown count left after the removal step.
    always_comb begin
        h_req = HW'(height_reg);
        cnt_s = HW'({1'b0, count_reg});
        if (h_req < H_HIDE) begin
            h_cl = H_HIDE;
        end else if (h_req > cnt_s) begin
            h_cl = cnt_s;
        end else begin
            h_cl = h_req;
        end
        do_ins = !h_cl[HW-1] && (count_reg < CW'(SLOTS));
        h_app  = do_ins ? h_cl : H_HIDE;
    end

    assign s_ready  = state_reg == S_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign layer_ok = 32'(s_layer) < 32'(SLOTS);
    assign level_ok = 32'(s_level) < 32'(count_reg);

    always_comb begin
        state_next      = state_reg;
        layer_next      = layer_reg;
        height_next     = height_reg;
        found_next      = found_reg;
        p_next          = p_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_layer_next  = res_layer_reg;
        res_height_next = res_height_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_layer_next    = m_layer_reg;
        m_height_next   = m_height_reg;
        m_count_next    = m_count_reg;
        cell_ctrl       = '0;
        cell_thr        = '0;
        pool_scan       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    layer_next  = s_layer;
                    height_next = s_height;
                    unique case (s_op)
                        lzs_pkg::OP_ALLOC: begin
                            state_next = S_ALLOC;
                        end
                        lzs_pkg::OP_SET_HEIGHT: begin
                            if (!layer_ok || !pool_in_use) begin
                                res_status_next = lzs_pkg::ST_EMPTY;
                                res_layer_next  = s_layer;
                                res_height_next = lzs_pkg::HEIGHT_HIDDEN;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_FIND;
                            end
                        end
                        lzs_pkg::OP_READ_LEVEL: begin
                            if (level_ok) begin
                                res_status_next = lzs_pkg::ST_OK;
                                res_layer_next  = 4'(rd_hit);
                                res_height_next = 5'(s_level);
                            end else begin
                                res_status_next = lzs_pkg::ST_EMPTY;
                                res_layer_next  = '0;
                                res_height_next = lzs_pkg::HEIGHT_HIDDEN;
                            end
                            state_next = S_DONE;
                        end
                        default: begin
                            // The unused op code is answered without any change.
                            res_status_next = lzs_pkg::ST_OK;
                            res_layer_next  = '0;
                            res_height_next = lzs_pkg::HEIGHT_HIDDEN;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                pool_scan = 1'b1;
                if (pool_stat.hit) begin
                    res_status_next = lzs_pkg::ST_OK;
                    res_layer_next  = 4'(pool_idx);
                    res_height_next = lzs_pkg::HEIGHT_HIDDEN;
                    state_next      = S_DONE;
                end else if (pool_stat.miss) begin
                    res_status_next = lzs_pkg::ST_NO_SLOT;
                    res_layer_next  = '0;
                    res_height_next = lzs_pkg::HEIGHT_HIDDEN;
                    state_next      = S_DONE;
                end
            end
            S_FIND: begin
                found_next = match_any;
                p_next     = p_enc;
                state_next = S_REMOVE;
            end
            S_REMOVE: begin
                cell_ctrl.remove = found_reg;
                cell_thr         = p_reg;
                if (found_reg) begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_INSERT;
            end
            S_INSERT: begin
                cell_ctrl.insert = do_ins;
                cell_thr         = LW'(h_cl);
                if (do_ins) begin
                    count_next = count_reg + CW'(1);
                end
                res_status_next = lzs_pkg::ST_OK;
                res_layer_next  = layer_reg;
                res_height_next = 5'(h_app);
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_layer_next  = res_layer_reg;
                    m_height_next = res_height_reg;
                    m_count_next  = 5'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        layer_reg      <= layer_next;
        height_reg     <= height_next;
        found_reg      <= found_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_layer_reg  <= res_layer_next;
        res_height_reg <= res_height_next;
        m_status_reg   <= m_status_next;
        m_layer_reg    <= m_layer_next;
        m_height_reg   <= m_height_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_layer_out   = m_layer_reg;
    assign m_height_out  = m_height_reg;
    assign m_shown_count = m_count_reg;

    `LZS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(SLOTS), "shown count exceeds pool size")
    `LZS_ASSERT_NOW(a_match_unique, aclk, aresetn, state_reg == S_FIND, $onehot0(match_vec), "layer shown at more than one level")
    `LZS_ASSERT_NEXT(a_remove_count, aclk, aresetn, (state_reg == S_REMOVE) && found_reg, count_reg == $past(count_reg) - CW'(1), "removal did not shrink the shown count")
    `LZS_ASSERT_NEXT(a_alloc_done, aclk, aresetn, (state_reg == S_ALLOC) && (pool_stat.hit || pool_stat.miss), state_reg == S_DONE, "slot search ended without a result")

endmodule

>>> tb/tb_layer_z_order_stack.sv
// Self-checking testbench for layer_z_order_stack: directed table, then random items.
// Depends on lzs_pkg and the layer_z_order_stack RTL; needs no files at run time.
`timescale 1ns / 1ps

// Every accepted input item is run through a local model of the level stack at
// the moment of acceptance, and the result it should produce is queued. Result
// items are taken off the queue in order and compared field by field. A short
// table of directed items comes first; a few rows of it carry their expected
// result typed in, the rest lean on the model. The random part then runs in
// four phases of handshake pressure: none, an idle sender, a stalling
// receiver, and both at once.

module tb_layer_z_order_stack;

    localparam int SLOT_COUNT   = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIR      = 16;

    // The package names no code for the spare op value, so it is named here.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        layer;
        logic signed [4:0] height;
        logic [4:0]        shown;
    } outcome_t;

    // One row of the directed table. A row is sent reps times; where typed is
    // set, want is the result to expect instead of the model's answer.
    typedef struct packed {
        logic [1:0]        op;
        logic [3:0]        layer;
        logic signed [7:0] height;
        logic [3:0]        level;
        logic [4:0]        reps;
        logic              typed;
        outcome_t          want;
    } stim_row_t;

    // Heights are written as raw bytes: 8'h7F is +127, 8'h80 is -128,
    // 8'hFF is -1 and 8'hFE is -2.
    localparam stim_row_t DIR_TABLE [0:NUM_DIR-1] = '{
        // Empty stack straight after reset: nothing at level 0.
        '{lzs_pkg::OP_READ_LEVEL, 4'd0, 8'h00, 4'd0, 5'd1, 1'b1,
          '{lzs_pkg::ST_EMPTY, 4'd0, lzs_pkg::HEIGHT_HIDDEN, 5'd0}},
        // Set-height on a slot that has never been allocated.
        '{lzs_pkg::OP_SET_HEIGHT, 4'd15, 8'h03, 4'd0, 5'd1, 1'b1,
          '{lzs_pkg::ST_EMPTY, 4'd15, lzs_pkg::HEIGHT_HIDDEN, 5'd0}},
        // The spare op code with layer and level at their top and the lowest height.
        '{OP_UNUSED, 4'd15, 8'h80, 4'd15, 5'd1, 1'b1,
          '{lzs_pkg::ST_OK, 4'd0, lzs_pkg::HEIGHT_HIDDEN, 5'd0}},
        // The first two allocations hand out slots 0 and 1, both hidden.
        '{lzs_pkg::OP_ALLOC, 4'd0, 8'h00, 4'd0, 5'd1, 1'b1,
          '{lzs_pkg::ST_OK, 4'd0, lzs_pkg::HEIGHT_HIDDEN, 5'd0}},
        '{lzs_pkg::OP_ALLOC, 4'd0, 8'h00, 4'd0, 5'd1, 1'b1,
          '{lzs_pkg::ST_OK, 4'd1, lzs_pkg::HEIGHT_HIDDEN, 5'd0}},
        // Largest height, clamped down to the shown count.
        '{lzs_pkg::OP_SET_HEIGHT, 4'd0, 8'h7F, 4'd0, 5'd1, 1'b0, '0},
        // Smallest height, clamped up to hidden.
        '{lzs_pkg::OP_SET_HEIGHT, 4'd1, 8'h80, 4'd0, 5'd1, 1'b0, '0},
        '{lzs_pkg::OP_SET_HEIGHT, 4'd1, 8'h09, 4'd0, 5'd1, 1'b0, '0},
        // Move a shown layer beneath another one.
        '{lzs_pkg::OP_SET_HEIGHT, 4'd1, 8'h00, 4'd0, 5'd1, 1'b0, '0},
        '{lzs_pkg::OP_READ_LEVEL, 4'd0, 8'h00, 4'd1, 5'd1, 1'b0, '0},
        '{lzs_pkg::OP_READ_LEVEL, 4'd0, 8'h00, 4'd0, 5'd1, 1'b0, '0},
        // Hide with exactly -1, then with a height below -1.
        '{lzs_pkg::OP_SET_HEIGHT, 4'd0, 8'hFF, 4'd0, 5'd1, 1'b0, '0},
        '{lzs_pkg::OP_SET_HEIGHT, 4'd1, 8'hFE, 4'd0, 5'd1, 1'b0, '0},
        '{lzs_pkg::OP_READ_LEVEL, 4'd0, 8'h00, 4'd15, 5'd1, 1'b0, '0},
        // Fill the rest of the pool, then ask once more with no slot left.
        '{lzs_pkg::OP_ALLOC, 4'd0, 8'h00, 4'd0, 5'd14, 1'b0, '0},
        '{lzs_pkg::OP_ALLOC, 4'd0, 8'h00, 4'd0, 5'd1, 1'b0, '0}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_op;
    logic [3:0]        s_layer;
    logic signed [7:0] s_height;
    logic [3:0]        s_level;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [3:0]        m_layer_out;
    logic signed [4:0] m_height_out;
    logic [4:0]        m_shown_count;

    // Local copy of the block's state.
    logic       slot_used  [SLOT_COUNT];
    int         lyr_height [SLOT_COUNT];
    logic [3:0] level_map  [SLOT_COUNT];
    int         shown_n;

    outcome_t   expected_q [$];
    int         err_cnt;
    int         cycle_cnt;
    int         idle_pct;
    int         stall_pct;

    layer_z_order_stack #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_layer      (s_layer),
        .s_height     (s_height),
        .s_level      (s_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_layer_out  (m_layer_out),
        .m_height_out (m_height_out),
        .m_shown_count(m_shown_count)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Applies one item to the local stack and works out the result it gives.
    // A set-height first takes the layer out of the order, closing the gap,
    // then clamps the height against the count left and opens a gap there.
    task automatic stack_apply(input logic [1:0] op, input logic [3:0] layer,
                               input logic signed [7:0] height, input logic [3:0] level,
                               output outcome_t res);
        int pos;
        int h;
        int i;
        res = '{lzs_pkg::ST_OK, 4'd0, lzs_pkg::HEIGHT_HIDDEN, 5'd0};
        case (op)
            lzs_pkg::OP_ALLOC: begin
                res.status = lzs_pkg::ST_NO_SLOT;
                for (i = SLOT_COUNT - 1; i >= 0; i--) begin
                    if (!slot_used[i]) begin
                        res.status = lzs_pkg::ST_OK;
                        res.layer  = 4'(i);
                    end
                end
                if (res.status == lzs_pkg::ST_OK) begin
                    slot_used[res.layer]  = 1'b1;
                    lyr_height[res.layer] = -1;
                end
            end
            lzs_pkg::OP_SET_HEIGHT: begin
                res.layer = layer;
                if (!slot_used[layer]) begin
                    res.status = lzs_pkg::ST_EMPTY;
                end else begin
                    if (lyr_height[layer] >= 0) begin
                        pos = -1;
                        for (i = 0; i < shown_n; i++) begin
                            if (pos < 0 && level_map[i] == layer) begin
                                pos = i;
                            end
                        end
                        if (pos >= 0) begin
                            for (i = pos; i + 1 < shown_n; i++) begin
                                level_map[i] = level_map[i + 1];
                            end
                            shown_n--;
                        end
                        lyr_height[layer] = -1;
                    end
                    h = int'(height);
                    if (h < -1) begin
                        h = -1;
                    end
                    if (h > shown_n) begin
                        h = shown_n;
                    end
                    if (h >= 0 && shown_n < SLOT_COUNT) begin
                        for (i = shown_n; i > h; i--) begin
                            level_map[i] = level_map[i - 1];
                        end
                        level_map[h] = layer;
                        shown_n++;
                    end else begin
                        h = -1;
                    end
                    lyr_height[layer] = h;
                    for (i = 0; i < shown_n; i++) begin
                        lyr_height[level_map[i]] = i;
                    end
                    res.height = 5'(h);
                end
            end
            lzs_pkg::OP_READ_LEVEL: begin
                if (int'(level) < shown_n) begin
                    res.layer  = level_map[level];
                    res.height = 5'(level);
                end else begin
                    res.status = lzs_pkg::ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
        res.shown = 5'(shown_n);
    endtask

    // Offers one item after a random idle gap, waits for it to be taken and
    // queues the result it should produce.
    task automatic send_item(input logic [1:0] op, input logic [3:0] layer,
                             input logic signed [7:0] height, input logic [3:0] level,
                             input logic typed, input outcome_t want);
        outcome_t res;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_layer  <= layer;
        s_height <= height;
        s_level  <= level;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        stack_apply(op, layer, height, level, res);
        expected_q.push_back(typed ? want : res);
    endtask

    // Random item. Most items move layers about, usually with heights near
    // the useful range, so that the order is reshuffled all the time; the rest
    // read levels, allocate or use the spare op. One item in four uses any byte as height.
    task automatic send_random_item();
        int         pick;
        logic [1:0] op;
        logic [7:0] height;
        pick = $urandom_range(99);
        if (pick < 8) begin
            op = lzs_pkg::OP_ALLOC;
        end else if (pick < 60) begin
            op = lzs_pkg::OP_SET_HEIGHT;
        end else if (pick < 95) begin
            op = lzs_pkg::OP_READ_LEVEL;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(3) == 0) begin
            height = 8'($urandom_range(255));
        end else begin
            height = 8'(int'($urandom_range(18)) - 1);
        end
        send_item(op, 4'($urandom_range(15)), height, 4'($urandom_range(15)), 1'b0, '0);
    endtask

    // The receiver decides afresh on every cycle whether to take a result.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result item with none expected: status %0d layer %0d",
                       m_status, m_layer_out);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    err_cnt++;
                end
                if (m_layer_out !== want.layer) begin
                    $error("layer_out: expected %0d, got %0d", want.layer, m_layer_out);
                    err_cnt++;
                end
                if (m_height_out !== want.height) begin
                    $error("height_out: expected %0d, got %0d",
                           want.height, m_height_out);
                    err_cnt++;
                end
                if (m_shown_count !== want.shown) begin
                    $error("shown_count: expected %0d, got %0d",
                           want.shown, m_shown_count);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_layer_z_order_stack: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int row;
        int n;
        int ph;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_op      = lzs_pkg::OP_ALLOC;
        s_layer   = 4'd0;
        s_height  = 8'sd0;
        s_level   = 4'd0;
        m_ready   = 1'b0;
        err_cnt   = 0;
        cycle_cnt = 0;
        idle_pct  = 0;
        stall_pct = 0;
        shown_n   = 0;
        for (n = 0; n < SLOT_COUNT; n++) begin
            slot_used[n]  = 1'b0;
            lyr_height[n] = 0;
            level_map[n]  = 4'd0;
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table with no idling on either side.
        for (row = 0; row < NUM_DIR; row++) begin
            for (n = 0; n < DIR_TABLE[row].reps; n++) begin
                send_item(DIR_TABLE[row].op, DIR_TABLE[row].layer, DIR_TABLE[row].height,
                          DIR_TABLE[row].level, DIR_TABLE[row].typed, DIR_TABLE[row].want);
            end
        end

        // Random items in four pressure phases.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                default: begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
                send_random_item();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb_layer_z_order_stack: PASS");
        end else begin
            $display("tb_layer_z_order_stack: FAIL");
        end
        $finish;
    end

endmodule
